@@ rtl/core/gap_buffer_line_editor_defines.svh @@
// assertion macros shared by the checker
`ifndef GAP_BUFFER_LINE_EDITOR_DEFINES_SVH
`define GAP_BUFFER_LINE_EDITOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GBL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/gble_pkg.sv @@
package gble_pkg;

	localparam int unsigned CAPACITY = 1024;
	localparam int unsigned AW       = $clog2(CAPACITY);
	localparam int unsigned CW       = $clog2(CAPACITY + 1);

	localparam int unsigned IN_W  = 32;
	localparam int unsigned OUT_W = 32;

	typedef enum logic [2:0] {
		OP_INSERT     = 3'd0,
		OP_FORWARD    = 3'd1,
		OP_BACKWARD   = 3'd2,
		OP_DELETE     = 3'd3,
		OP_KILL_END   = 3'd4,
		OP_KILL_START = 3'd5,
		OP_CLEAR      = 3'd6,
		OP_READ       = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic move_rd;
		logic move_wr;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_move;
		logic move_none;
		logic move_last;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/core/gble_ctrl.sv @@
module gble_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  gble_pkg::dp_status_t   status,
	output gble_pkg::ctrl_cmd_t    cmd
);
	import gble_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.is_move && !status.move_none) state_next = ST_MOVE_RD;
				else state_next = ST_DONE;
			end
			ST_MOVE_RD: begin
				state_next = ST_MOVE_WR;
			end
			ST_MOVE_WR: begin
				if (status.move_last) state_next = ST_DONE;
				else state_next = ST_MOVE_RD;
			end
			ST_DONE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.latch    = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.move_rd  = (state_q == ST_MOVE_RD);
		cmd.move_wr  = (state_q == ST_MOVE_WR);
		cmd.out_load = (state_q == ST_DONE) && status.out_free;
	end

endmodule

@@ rtl/core/gble_dpath.sv @@
module gble_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gble_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [gble_pkg::OUT_W-1:0]  m_tdata,
	input  gble_pkg::ctrl_cmd_t         cmd,
	output gble_pkg::dp_status_t        status
);
	import gble_pkg::*;

	// latched command
	op_t           op_q;
	logic [7:0]    char_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;

	// cursor state
	logic [CW-1:0] before_q;
	logic [CW-1:0] after_q;
	logic [CW-1:0] rem_q;
	logic          rd_hit_q;
	logic          drop_q;

	// text store
	logic [7:0]    mem_q [CAPACITY];
	logic [7:0]    rdata_q;

	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic [CW-1:0] out_cursor_q;
	logic [CW-1:0] out_len_q;
	logic          out_drop_q;

	logic [CW-1:0] len_w;
	logic [CW-1:0] gap_w;
	logic          full_w;
	logic [CW-1:0] move_n_w;
	logic [CW-1:0] pos_ext_w;
	logic [CW-1:0] off_w;
	logic          in_before_w;
	logic          in_after_w;
	logic [CW-1:0] rd_addr_w;
	logic [CW-1:0] src_w;
	logic [CW-1:0] dst_w;
	logic          we_w;
	logic [AW-1:0] waddr_w;
	logic [7:0]    wdata_w;
	logic          re_w;
	logic [AW-1:0] raddr_w;
	logic          is_fwd_w;

	assign len_w       = before_q + after_q;
	assign gap_w       = CW'(CAPACITY) - len_w;
	assign full_w      = (len_w == CW'(CAPACITY));
	assign is_fwd_w    = (op_q == OP_FORWARD);
	assign pos_ext_w   = {{(CW-AW){1'b0}}, pos_q};
	assign off_w       = pos_ext_w - before_q;
	assign in_before_w = (pos_ext_w < before_q);
	assign in_after_w  = !in_before_w && (off_w < after_q);
	// positions after the cursor sit past the gap
	assign rd_addr_w   = in_before_w ? pos_ext_w : (pos_ext_w + gap_w);
	assign src_w       = is_fwd_w ? (CW'(CAPACITY) - after_q) : (before_q - CW'(1));
	assign dst_w       = is_fwd_w ? before_q : (CW'(CAPACITY) - after_q - CW'(1));

	always_comb begin
		if (is_fwd_w) move_n_w = (count_q < after_q) ? count_q : after_q;
		else move_n_w = (count_q < before_q) ? count_q : before_q;
	end

	assign status.is_move   = (op_q == OP_FORWARD) || (op_q == OP_BACKWARD);
	assign status.move_none = (move_n_w == '0);
	assign status.move_last = (rem_q == CW'(1));
	assign status.out_free  = !out_valid_q || m_tready;

	always_comb begin
		we_w    = 1'b0;
		waddr_w = before_q[AW-1:0];
		wdata_w = char_q;
		re_w    = 1'b0;
		raddr_w = src_w[AW-1:0];
		if (cmd.exec && (op_q == OP_INSERT) && !full_w) begin
			we_w = 1'b1;
		end
		if (cmd.move_wr) begin
			we_w    = 1'b1;
			waddr_w = dst_w[AW-1:0];
			wdata_w = rdata_q;
		end
		if (cmd.exec && (op_q == OP_READ) && (in_before_w || in_after_w)) begin
			re_w    = 1'b1;
			raddr_w = rd_addr_w[AW-1:0];
		end
		if (cmd.move_rd) begin
			re_w = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we_w) mem_q[waddr_w] <= wdata_w;
		if (re_w) rdata_q <= mem_q[raddr_w];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op_t'(s_tdata[2:0]);
			char_q  <= s_tdata[10:3];
			count_q <= s_tdata[21:11];
			pos_q   <= s_tdata[31:22];
		end
		if (cmd.out_load) begin
			out_char_q   <= rd_hit_q ? rdata_q : 8'd0;
			out_cursor_q <= before_q;
			out_len_q    <= len_w;
			out_drop_q   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			before_q <= '0;
			after_q  <= '0;
			rem_q    <= '0;
			rd_hit_q <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			if (cmd.exec) begin
				rem_q    <= move_n_w;
				rd_hit_q <= (op_q == OP_READ) && (in_before_w || in_after_w);
				drop_q   <= (op_q == OP_INSERT) && full_w;
				unique case (op_q)
					OP_INSERT: begin
						if (!full_w) before_q <= before_q + CW'(1);
					end
					OP_DELETE: begin
						if (after_q != '0) after_q <= after_q - CW'(1);
					end
					OP_KILL_END: begin
						after_q <= '0;
					end
					OP_KILL_START: begin
						before_q <= '0;
					end
					OP_CLEAR: begin
						before_q <= '0;
						after_q  <= '0;
					end
					OP_FORWARD, OP_BACKWARD, OP_READ: begin
					end
					default: begin
					end
				endcase
			end
			if (cmd.move_wr) begin
				rem_q <= rem_q - CW'(1);
				if (is_fwd_w) begin
					before_q <= before_q + CW'(1);
					after_q  <= after_q - CW'(1);
				end else begin
					before_q <= before_q - CW'(1);
					after_q  <= after_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_drop_q, out_len_q, out_cursor_q, out_char_q};

endmodule

@@ rtl/core/gap_buffer_line_editor.sv @@
// gap buffer line editor: one line of up to 1024 bytes with a cursor
//
// input stream (s_*): one edit command per transaction, fields packed in
//   s_tdata as op, char_in, count, position from bit 0 up
// output stream (m_*): exactly one result per command, in command order:
//   char_out, cursor, text_length, insert_dropped from bit 0 up
// commands run one at a time: insert, delete, kill, clear and read go from the
//   accepting edge through execute and result hand-off to m_tvalid; a cursor
//   move of n characters (n clamped at the text ends) adds a read and then a
//   write per moved character, the write taking the registered read data
// with a ready receiver a command passes through the ready cycle, execute,
//   move loop and result hand-off before the next command is taken
// the next command is accepted as soon as the previous result sits in the
//   output register, so a stalled receiver holds back at most one result
//   while the next command is already being worked on
// when the receiver stalls with a result pending, the finished command
//   waits and s_tready stays low until the output register frees up
// reset empties the line (cursor and length zero) with no clearing pass;
//   the store itself is not cleared, unread bytes are never visible
// a full store drops an insert and sets insert_dropped
module gap_buffer_line_editor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// op[2:0], char_in[10:3], count[21:11], position[31:22]
	input  logic [gble_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// char_out[7:0], cursor[18:8], text_length[29:19], insert_dropped[30], zero[31]
	output logic [gble_pkg::OUT_W-1:0]  m_tdata
);
	import gble_pkg::*;

	// controller to datapath commands and back
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer: idle, execute, move loop, result hand-off
	gble_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// store, cursor counts and output register
	gble_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

@@ rtl/core/gble_checker.sv @@
`include "gap_buffer_line_editor_defines.svh"

module gble_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [gble_pkg::OUT_W-1:0]  m_tdata
);
	import gble_pkg::*;

	`GBL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`GBL_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "command accepted while busy")
	`GBL_ASSERT_NOW(a_cursor_in_text, m_tvalid, m_tdata[18:8] <= m_tdata[29:19], "cursor past end of text")
	`GBL_ASSERT_NOW(a_drop_when_full, m_tvalid && m_tdata[30], m_tdata[29:19] == CW'(CAPACITY), "insert dropped with room left")

endmodule

bind gap_buffer_line_editor gble_checker u_gble_checker (.*);
